// File: rtl/lsmf_pkg.sv
// ----------------------------------------------------------------------------
// lsmf_pkg: lidar sector minimum filter shared types
// Word layouts, register indexes and fixed widths of the sector filter.
// ----------------------------------------------------------------------------
package lsmf_pkg;

	localparam int ANGLE_W     = 9;
	localparam int RANGE_W     = 16;
	localparam int RAY_IDX_W   = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int WEIGHT_W    = 16;

	localparam int FULL_CIRCLE = 360;
	localparam int WIN_LEN     = 5;

	localparam logic [RANGE_W-1:0] RANGE_ALL_ONES = '1;

	localparam logic [RANGE_W-1:0]  RANGE_LIMIT_RST  = 16'd2000;
	localparam logic [RANGE_W-1:0]  OBSTACLE_RST     = 16'd170;
	localparam logic [WEIGHT_W-1:0] KEEP_WEIGHT_RST  = 16'd66;
	localparam logic [ANGLE_W-1:0]  WINDOW_START_RST = 9'd227;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_LIMIT  = 2'd0,
		REG_OBSTACLE     = 2'd1,
		REG_KEEP_WEIGHT  = 2'd2,
		REG_WINDOW_START = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_index;
		logic [RANGE_W-1:0] range_mm;
		logic               range_valid;
	} in_word_t;

	typedef struct packed {
		logic [RAY_IDX_W-1:0] ray_index;
		logic [RANGE_W-1:0]   filtered_range;
		logic                 ray_hit;
		logic                 scan_hit;
		logic                 scan_last;
	} out_word_t;

endpackage

// File: rtl/lidar_sector_min_filter.sv
// ----------------------------------------------------------------------------
// lidar_sector_min_filter: per-ray minimum and smoothing of a lidar scan
// Reduces a stream of angle-ordered range samples to a fixed set of rays.
// ----------------------------------------------------------------------------
// One sample word is taken every cycle while in_ready is high. The work
// runs through a five-stage pipeline: window position (angle offset and a
// reciprocal multiply for the ray number), window membership, running
// window minimum with clamp, the exponential average (one 17x17 multiply
// against the stored ray value), then the obstacle compare and scan flags
// into the output register. The result of the sample that closes a window
// is registered stage by stage up to the output register.
// The pipeline only stops when a result reaches the last stage while the
// output register still holds a word that is not taken; samples that give
// no result keep flowing behind a waiting output word. No clearing pass is
// needed after reset; the per-ray store resets directly.
// ----------------------------------------------------------------------------
module lidar_sector_min_filter #(
	parameter int RAY_COUNT   = 18,
	parameter int RAY_SPACING = 15
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_we,
	input  logic [lsmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lsmf_pkg::CFG_DATA_W-1:0]     cfg_data,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  lsmf_pkg::in_word_t                  in_data,

	output logic                                out_valid,
	input  logic                                out_ready,
	output lsmf_pkg::out_word_t                 out_data
);

	localparam int RAY_W   = $clog2(RAY_COUNT);
	localparam int OFS_W   = lsmf_pkg::ANGLE_W;
	localparam int QUOT_W  = 7;                 // max offset / min spacing
	localparam int RECIP_W = 17;
	localparam int PROD_W  = OFS_W + RECIP_W;
	localparam int RECIP   = (1 << 16) / RAY_SPACING + 1;
	localparam int RANGE_W = lsmf_pkg::RANGE_W;

	// configuration
	logic [RANGE_W-1:0]              range_limit_q;
	logic [RANGE_W-1:0]              obstacle_q;
	logic [lsmf_pkg::WEIGHT_W-1:0]   keep_weight_q;
	logic [lsmf_pkg::ANGLE_W-1:0]    start_q;      // kept reduced mod 360

	logic [lsmf_pkg::ANGLE_W-1:0]    cfg_angle;

	assign cfg_angle = cfg_data[lsmf_pkg::ANGLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_limit_q <= lsmf_pkg::RANGE_LIMIT_RST;
			obstacle_q    <= lsmf_pkg::OBSTACLE_RST;
			keep_weight_q <= lsmf_pkg::KEEP_WEIGHT_RST;
			start_q       <= lsmf_pkg::WINDOW_START_RST;
		end else if (cfg_we) begin
			unique case (lsmf_pkg::cfg_reg_t'(cfg_index))
				lsmf_pkg::REG_RANGE_LIMIT:  range_limit_q <= cfg_data;
				lsmf_pkg::REG_OBSTACLE:     obstacle_q    <= cfg_data;
				lsmf_pkg::REG_KEEP_WEIGHT:  keep_weight_q <= cfg_data;
				lsmf_pkg::REG_WINDOW_START: begin
					if (cfg_angle >= lsmf_pkg::ANGLE_W'(lsmf_pkg::FULL_CIRCLE))
						start_q <= cfg_angle - lsmf_pkg::ANGLE_W'(lsmf_pkg::FULL_CIRCLE);
					else
						start_q <= cfg_angle;
				end
				default: ;
			endcase
		end
	end

	// pipeline advance
	logic en;
	logic out_free;
	logic close_s5;

	assign out_free = !out_valid || out_ready;
	assign en       = out_free || !close_s5;
	assign in_ready = en;

	// stage 1: input register
	logic                          v_s1;
	lsmf_pkg::in_word_t            word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en && in_valid)
			word_s1 <= in_data;
	end

	// offset from window start and ray estimate
	logic [OFS_W:0]   sum_s1;
	logic [OFS_W-1:0] offset_s1;
	logic [PROD_W-1:0] quot_prod_s1;
	logic             in_circle_s1;

	assign in_circle_s1 = word_s1.angle_index < lsmf_pkg::ANGLE_W'(lsmf_pkg::FULL_CIRCLE);
	assign sum_s1 = {1'b0, word_s1.angle_index} + (OFS_W+1)'(lsmf_pkg::FULL_CIRCLE)
		- {1'b0, start_q};
	assign offset_s1 = (sum_s1 >= (OFS_W+1)'(lsmf_pkg::FULL_CIRCLE))
		? OFS_W'(sum_s1 - (OFS_W+1)'(lsmf_pkg::FULL_CIRCLE)) : sum_s1[OFS_W-1:0];
	assign quot_prod_s1 = PROD_W'(offset_s1) * PROD_W'(RECIP);

	// stage 2
	logic              v_s2;
	logic [OFS_W-1:0]  offset_s2;
	logic [QUOT_W-1:0] quot_s2;
	logic [RANGE_W-1:0] range_s2;
	logic              rvalid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1 && in_circle_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			offset_s2 <= offset_s1;
			quot_s2   <= quot_prod_s1[16 +: QUOT_W];
			range_s2  <= word_s1.range_mm;
			rvalid_s2 <= word_s1.range_valid;
		end
	end

	logic [OFS_W-1:0] pos_s2;
	logic             in_win_s2;

	assign pos_s2 = offset_s2 - OFS_W'(OFS_W'(quot_s2) * OFS_W'(RAY_SPACING));
	assign in_win_s2 = v_s2 && (QUOT_W'(quot_s2) < QUOT_W'(RAY_COUNT))
		&& (pos_s2 < OFS_W'(lsmf_pkg::WIN_LEN));

	// stage 3: window minimum
	logic               v_s3;
	logic               first_s3;
	logic               last_s3;
	logic [RAY_W-1:0]   ray_s3;
	logic [RANGE_W-1:0] range_s3;
	logic               rvalid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en)
			v_s3 <= in_win_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			first_s3  <= pos_s2 == '0;
			last_s3   <= pos_s2 == OFS_W'(lsmf_pkg::WIN_LEN - 1);
			ray_s3    <= RAY_W'(quot_s2);
			range_s3  <= range_s2;
			rvalid_s3 <= rvalid_s2;
		end
	end

	logic [RANGE_W-1:0] window_min_q;
	logic [RANGE_W-1:0] min_base_s3;
	logic [RANGE_W-1:0] min_new_s3;
	logic [RANGE_W-1:0] clamped_s3;

	assign min_base_s3 = first_s3 ? lsmf_pkg::RANGE_ALL_ONES : window_min_q;
	assign min_new_s3  = (rvalid_s3 && range_s3 < min_base_s3) ? range_s3 : min_base_s3;
	assign clamped_s3  = (min_new_s3 < range_limit_q) ? min_new_s3 : range_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			window_min_q <= lsmf_pkg::RANGE_ALL_ONES;
		else if (en && v_s3)
			window_min_q <= last_s3 ? lsmf_pkg::RANGE_ALL_ONES : min_new_s3;
	end

	// stage 4: exponential average, w*old + (1-w)*new = new + w*(old - new)
	logic               close_s4;
	logic [RAY_W-1:0]   ray_s4;
	logic [RANGE_W-1:0] clamped_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			close_s4 <= 1'b0;
		else if (en)
			close_s4 <= v_s3 && last_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s4     <= ray_s3;
			clamped_s4 <= clamped_s3;
		end
	end

	logic [RANGE_W-1:0]        ray_filt_q [RAY_COUNT];
	logic [RANGE_W-1:0]        old_s4;
	logic signed [RANGE_W:0]   diff_s4;
	logic signed [2*RANGE_W+1:0] prod_s4;
	logic signed [2*RANGE_W+2:0] acc_s4;
	logic [RANGE_W-1:0]        filt_s4;

	assign old_s4  = ray_filt_q[ray_s4];
	assign diff_s4 = $signed({1'b0, old_s4}) - $signed({1'b0, clamped_s4});
	assign prod_s4 = diff_s4 * $signed({1'b0, keep_weight_q});
	assign acc_s4  = $signed({3'b000, clamped_s4, 16'h0000}) + (2*RANGE_W+3)'(prod_s4)
		+ (2*RANGE_W+3)'(32768);
	assign filt_s4 = acc_s4[16 +: RANGE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < RAY_COUNT; k++)
				ray_filt_q[k] <= '0;
		end else if (en && close_s4) begin
			ray_filt_q[ray_s4] <= filt_s4;
		end
	end

	// stage 5: obstacle and scan flags
	logic [RAY_W-1:0]   ray_s5;
	logic [RANGE_W-1:0] filt_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			close_s5 <= 1'b0;
		else if (en)
			close_s5 <= close_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s5  <= ray_s4;
			filt_s5 <= filt_s4;
		end
	end

	logic                           hit_so_far_q;
	logic [lsmf_pkg::RAY_IDX_W-1:0] rays_done_q;
	logic                           hit_s5;
	logic                           scan_hit_s5;
	logic                           last_s5;

	assign hit_s5      = filt_s5 < obstacle_q;
	assign scan_hit_s5 = hit_so_far_q || hit_s5;
	assign last_s5     = rays_done_q >= lsmf_pkg::RAY_IDX_W'(RAY_COUNT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_so_far_q <= 1'b0;
			rays_done_q  <= '0;
		end else if (en && close_s5) begin
			if (last_s5) begin
				hit_so_far_q <= 1'b0;
				rays_done_q  <= '0;
			end else begin
				hit_so_far_q <= scan_hit_s5;
				rays_done_q  <= rays_done_q + 1'b1;
			end
		end
	end

	// output register
	logic               out_valid_q;
	lsmf_pkg::out_word_t out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= close_s5;
	end

	always_ff @(posedge clk) begin
		if (out_free && close_s5) begin
			out_word_q.ray_index      <= lsmf_pkg::RAY_IDX_W'(ray_s5);
			out_word_q.filtered_range <= filt_s5;
			out_word_q.ray_hit        <= hit_s5;
			out_word_q.scan_hit       <= scan_hit_s5;
			out_word_q.scan_last      <= last_s5;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	// checks
	a_rays_done_range: assert property (@(posedge clk) disable iff (!arst_n)
		rays_done_q < lsmf_pkg::RAY_IDX_W'(RAY_COUNT))
		else $error("ray counter beyond ray count");

	a_scan_hit_covers_ray: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_word_q.ray_hit || out_word_q.scan_hit))
		else $error("ray hit without scan hit");

	a_scan_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(en && close_s5 && last_s5) |=> (rays_done_q == '0 && !hit_so_far_q))
		else $error("scan state not cleared after last ray");

	a_stall_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en) |=> ($stable(window_min_q)))
		else $error("window minimum moved during stall");

endmodule

// File: dv/lidar_sector_min_filter_test.sv
// ----------------------------------------------------------------------------
// lidar_sector_min_filter_test: self-checking bench for the sector filter
// Streams range samples through the filter with random gaps and output
// stalls. A local model of the window minimum, clamp and Q0.16 smoothing
// predicts every ray result, and each one is checked in order.
// ----------------------------------------------------------------------------
module lidar_sector_min_filter_test;

	localparam int RAY_COUNT    = 18;
	localparam int RAY_SPACING  = 15;
	localparam int DRAIN_CYCLES = 10;
	localparam int STALL_LIMIT  = 2000;
	localparam int ITEM_TARGET  = 1800;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [lsmf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [lsmf_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	lsmf_pkg::in_word_t              in_data;
	logic                            out_valid;
	logic                            out_ready;
	lsmf_pkg::out_word_t             out_data;

	// model copy of the registers and of the filter state
	logic [lsmf_pkg::RANGE_W-1:0]  cfg_range_limit;
	logic [lsmf_pkg::RANGE_W-1:0]  cfg_obstacle;
	logic [lsmf_pkg::WEIGHT_W-1:0] cfg_keep_weight;
	logic [lsmf_pkg::ANGLE_W-1:0]  cfg_window_start;
	logic [lsmf_pkg::RANGE_W-1:0]  win_min;
	logic [lsmf_pkg::RANGE_W-1:0]  ray_smoothed [RAY_COUNT];
	logic                          scan_hit_acc;
	int unsigned                   rays_closed;

	lsmf_pkg::out_word_t expected_rays [$];
	lsmf_pkg::out_word_t want;
	int unsigned sent_items;
	int unsigned fail_count;
	int unsigned idle_cycles;
	int unsigned in_gap_max;
	int unsigned out_stall_max;
	int unsigned out_stall;

	lidar_sector_min_filter #(
		.RAY_COUNT   (RAY_COUNT),
		.RAY_SPACING (RAY_SPACING)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ray and window slot of an angle under the current start; 0 if ignored
	function automatic bit locate(input logic [lsmf_pkg::ANGLE_W-1:0] angle,
			output int unsigned ray, output int unsigned pos);
		int unsigned start;
		int unsigned offset;
		ray = 0;
		pos = 0;
		if (angle >= lsmf_pkg::FULL_CIRCLE)
			return 1'b0;
		start  = cfg_window_start % lsmf_pkg::FULL_CIRCLE;
		offset = (angle + lsmf_pkg::FULL_CIRCLE - start) % lsmf_pkg::FULL_CIRCLE;
		ray    = offset / RAY_SPACING;
		pos    = offset % RAY_SPACING;
		return (ray < RAY_COUNT) && (pos < lsmf_pkg::WIN_LEN);
	endfunction

	function automatic void smooth_window_sample(input lsmf_pkg::in_word_t w);
		int unsigned ray;
		int unsigned pos;
		logic [lsmf_pkg::RANGE_W-1:0] clamped;
		logic [lsmf_pkg::RANGE_W-1:0] filt;
		logic [33:0] acc;
		lsmf_pkg::out_word_t res;
		if (!locate(w.angle_index, ray, pos))
			return;
		if (pos == 0)
			win_min = lsmf_pkg::RANGE_ALL_ONES;
		if (w.range_valid && w.range_mm < win_min)
			win_min = w.range_mm;
		if (pos != lsmf_pkg::WIN_LEN - 1)
			return;
		clamped = (win_min < cfg_range_limit) ? win_min : cfg_range_limit;
		acc = 34'(cfg_keep_weight) * 34'(ray_smoothed[ray])
			+ (34'd65536 - 34'(cfg_keep_weight)) * 34'(clamped) + 34'd32768;
		filt = acc[31:16];
		ray_smoothed[ray] = filt;
		win_min = lsmf_pkg::RANGE_ALL_ONES;
		res.ray_index      = lsmf_pkg::RAY_IDX_W'(ray);
		res.filtered_range = filt;
		res.ray_hit        = filt < cfg_obstacle;
		res.scan_hit       = scan_hit_acc | res.ray_hit;
		scan_hit_acc       = res.scan_hit;
		rays_closed++;
		res.scan_last      = 1'b0;
		if (rays_closed >= RAY_COUNT) begin
			res.scan_last = 1'b1;
			scan_hit_acc  = 1'b0;
			rays_closed   = 0;
		end
		expected_rays = {expected_rays, res};
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_sample(input int unsigned angle, input int unsigned range,
			input bit valid);
		int unsigned gap;
		lsmf_pkg::in_word_t w;
		w.angle_index = lsmf_pkg::ANGLE_W'(angle);
		w.range_mm    = lsmf_pkg::RANGE_W'(range);
		w.range_valid = valid;
		gap = $urandom_range(0, in_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		sent_items++;
		smooth_window_sample(w);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_rays.size() != 0)
			@(negedge clk);
		// samples that close no window may still be in the pipeline
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input lsmf_pkg::cfg_reg_t idx,
			input logic [lsmf_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			lsmf_pkg::REG_RANGE_LIMIT:  cfg_range_limit  = value;
			lsmf_pkg::REG_OBSTACLE:     cfg_obstacle     = value;
			lsmf_pkg::REG_KEEP_WEIGHT:  cfg_keep_weight  = value;
			lsmf_pkg::REG_WINDOW_START: cfg_window_start = value[lsmf_pkg::ANGLE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input int unsigned range_limit, input int unsigned obstacle,
			input int unsigned weight, input int unsigned start);
		wait_idle();
		write_reg(lsmf_pkg::REG_RANGE_LIMIT, lsmf_pkg::CFG_DATA_W'(range_limit));
		write_reg(lsmf_pkg::REG_OBSTACLE, lsmf_pkg::CFG_DATA_W'(obstacle));
		write_reg(lsmf_pkg::REG_KEEP_WEIGHT, lsmf_pkg::CFG_DATA_W'(weight));
		write_reg(lsmf_pkg::REG_WINDOW_START, lsmf_pkg::CFG_DATA_W'(start));
	endtask

	function automatic int unsigned pick_range();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 16'hFFFF;
			2: return $urandom_range(0, 300);
			3: return $urandom_range(0, 3000);
			default: return $urandom_range(0, 16'hFFFF);
		endcase
	endfunction

	task automatic test_field_extremes();
		apply_settings(16'hFFFF, 16'hFFFF, 0, 0);
		send_sample(0, 16'hFFFF, 1'b1);
		send_sample(1, 0, 1'b0);
		send_sample(2, 12345, 1'b1);
		send_sample(3, 16'hFFFF, 1'b0);
		send_sample(4, 40000, 1'b1);
	endtask

	task automatic test_invalid_window();
		// all five invalid: minimum stays all ones, then clamp
		for (int a = 15; a < 20; a++)
			send_sample(a, 0, 1'b0);
	endtask

	task automatic test_window_restart();
		// ray 2 opens but never closes; ray 3 must start fresh
		send_sample(30, 7, 1'b1);
		send_sample(31, 9, 1'b1);
		for (int a = 45; a < 50; a++)
			send_sample(a, 500 + a, 1'b1);
		// window with no first word after a close
		send_sample(62, 900, 1'b1);
		send_sample(63, 16'hFFFF, 1'b0);
		send_sample(64, 1200, 1'b1);
	endtask

	task automatic test_ignored_samples();
		send_sample(5, 0, 1'b1);
		send_sample(300, 0, 1'b1);
		send_sample(400, 0, 1'b1);
		send_sample(511, 16'hFFFF, 1'b1);
	endtask

	task automatic test_wrap_window();
		apply_settings(1000, 500, 32768, 358);
		send_sample(358, 800, 1'b1);
		send_sample(359, 2500, 1'b1);
		send_sample(0, 300, 1'b1);
		send_sample(1, 100, 1'b0);
		send_sample(2, 650, 1'b1);
	endtask

	task automatic test_random_scans();
		int unsigned phase;
		int unsigned ray;
		int unsigned pos;
		bit broken;
		phase = 0;
		while (sent_items < ITEM_TARGET) begin
			case (phase)
				0: apply_settings(0, 0, 0, 0);
				1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 511);
				2: apply_settings(lsmf_pkg::RANGE_LIMIT_RST, lsmf_pkg::OBSTACLE_RST,
					lsmf_pkg::KEEP_WEIGHT_RST, lsmf_pkg::WINDOW_START_RST);
				default: apply_settings($urandom_range(0, 1) ? $urandom_range(200, 5000)
						: $urandom_range(0, 16'hFFFF),
					$urandom_range(0, 3) != 0 ? $urandom_range(0, 3000)
						: $urandom_range(0, 16'hFFFF),
					$urandom_range(0, 16'hFFFF), $urandom_range(0, 511));
			endcase
			in_gap_max    = (phase % 3 == 2) ? 0 : 6;
			out_stall_max = (phase % 4 == 3) ? 0 : 6;
			for (int s = 0; s < 3 && sent_items < ITEM_TARGET; s++) begin
				broken = ($urandom_range(0, 6) == 0);
				for (int a = 0; a < lsmf_pkg::FULL_CIRCLE; a++) begin
					if (locate(lsmf_pkg::ANGLE_W'(a), ray, pos)) begin
						if (!broken || $urandom_range(0, 3) != 0)
							send_sample(a, pick_range(), $urandom_range(0, 9) != 0);
					end else if ($urandom_range(0, 29) == 0) begin
						send_sample(a, pick_range(), 1'($urandom_range(0, 1)));
					end
					if (broken && $urandom_range(0, 19) == 0)
						send_sample($urandom_range(0, 511), pick_range(),
							1'($urandom_range(0, 1)));
				end
			end
			phase++;
		end
	endtask

	// result side: ready held low for the drawn stall after each taken word
	initial begin
		out_ready = 1'b0;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (out_stall > 0) begin
				out_ready <= 1'b0;
				out_stall = out_stall - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_rays.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected word: ray %0d range %0d hit %0b scan %0b last %0b",
						out_data.ray_index, out_data.filtered_range, out_data.ray_hit,
						out_data.scan_hit, out_data.scan_last);
				fail_count++;
			end else begin
				want = expected_rays.pop_front();
				if (out_data.ray_index !== want.ray_index
						|| out_data.filtered_range !== want.filtered_range
						|| out_data.ray_hit !== want.ray_hit
						|| out_data.scan_hit !== want.scan_hit
						|| out_data.scan_last !== want.scan_last) begin
					if (fail_count < 10)
						$display("mismatch: exp ray %0d range %0d hit %0b scan %0b last %0b, %s",
							want.ray_index, want.filtered_range, want.ray_hit,
							want.scan_hit, want.scan_last,
							$sformatf("got ray %0d range %0d hit %0b scan %0b last %0b",
								out_data.ray_index, out_data.filtered_range,
								out_data.ray_hit, out_data.scan_hit, out_data.scan_last));
					fail_count++;
				end
			end
			out_stall = $urandom_range(0, out_stall_max);
		end
	end

	// cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = lsmf_pkg::REG_RANGE_LIMIT;
		cfg_data         = '0;
		in_valid         = 1'b0;
		in_data          = '0;
		fail_count       = 0;
		idle_cycles      = 0;
		sent_items       = 0;
		in_gap_max       = 6;
		out_stall_max    = 6;
		cfg_range_limit  = lsmf_pkg::RANGE_LIMIT_RST;
		cfg_obstacle     = lsmf_pkg::OBSTACLE_RST;
		cfg_keep_weight  = lsmf_pkg::KEEP_WEIGHT_RST;
		cfg_window_start = lsmf_pkg::WINDOW_START_RST;
		win_min          = lsmf_pkg::RANGE_ALL_ONES;
		scan_hit_acc     = 1'b0;
		rays_closed      = 0;
		for (int k = 0; k < RAY_COUNT; k++)
			ray_smoothed[k] = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_field_extremes();
		test_invalid_window();
		test_window_restart();
		test_ignored_samples();
		test_wrap_window();
		test_random_scans();
		wait_idle();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
